// ===== sv/vmn_pkg.sv =====
// vmn_pkg: shared widths, codes and helpers for the vector/matrix norm unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package vmn_pkg;

  localparam int ELEM_BITS     = 24;
  localparam int MAG_BITS      = ELEM_BITS;
  localparam int PROD_BITS     = 2 * MAG_BITS;
  localparam int SQ_BITS       = 59;
  localparam int SQ_WORK_BITS  = SQ_BITS + 1;
  localparam int ROOT_BITS     = (SQ_BITS + 1) / 2;
  localparam int ROOT_TOP      = ((SQ_BITS - 1) / 2) * 2;
  localparam int ACC_BITS      = 36;
  localparam int NORM_BITS     = 36;
  localparam int MODE_BITS     = 3;
  localparam int EXT_BITS      = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 1;
  localparam int MAX_LEN       = 4096;
  localparam int MAX_DIM       = 64;
  localparam int CNT_BITS      = $clog2(MAX_LEN + 1);
  localparam int COL_BITS      = $clog2(MAX_DIM);
  localparam int SIDE_BITS     = $clog2(MAX_DIM + 1);

  localparam logic [EXT_BITS-1:0] EXTENT_RESET = EXT_BITS'(1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORM_MODE,
    REG_EXTENT
  } cfg_reg_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_VEC_L1,
    MODE_VEC_MAX,
    MODE_VEC_L2,
    MODE_MAT_INF,
    MODE_MAT_L1,
    MODE_FROB
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ROOT,
    ST_DONE
  } state_t;

  function automatic logic [MAG_BITS-1:0] magnitude(input logic [ELEM_BITS-1:0] raw);
    logic [MAG_BITS-1:0] v;
    v = raw;
    if (raw[ELEM_BITS-1]) begin
      v = ~raw + MAG_BITS'(1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/vmn_isqrt.sv =====
// vmn_isqrt: iterative floor square root, two radicand bits per cycle.
// Depends on vmn_pkg.
`default_nettype none

module vmn_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [vmn_pkg::SQ_BITS-1:0]  radicand,
  output logic                              done,
  output logic [vmn_pkg::ROOT_BITS-1:0]     root
);
  import vmn_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [SQ_WORK_BITS-1:0] rem_r, rem_nxt;
  logic [SQ_WORK_BITS-1:0] root_r, root_nxt;
  logic [SQ_WORK_BITS-1:0] bit_r, bit_nxt;
  logic [SQ_WORK_BITS-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = SQ_WORK_BITS'(radicand);
      root_nxt = '0;
      bit_nxt  = SQ_WORK_BITS'(1) << ROOT_TOP;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign done = done_r;
  assign root = root_r[ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== sv/vector_matrix_norm_unit_top.sv =====
// vector_matrix_norm_unit_top: streaming vector/matrix norms over Q7.16 elements.
// Elements are taken one at a time: accept, square/accumulate and sum of squares states
// finish before the next is accepted. Results pass through ST_DONE to the output register,
// via the shared square root in 2-norm and Frobenius modes; a result stall holds them.
// Reset (synchronous, active low): mode 0, extent 1, accumulators cleared,
// column sums invalidated through per-column valid bits. Depends on vmn_pkg, vmn_isqrt.
`default_nettype none

module vector_matrix_norm_unit_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [vmn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [vmn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [vmn_pkg::ELEM_BITS-1:0] in_element,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [vmn_pkg::NORM_BITS-1:0]           out_norm_value
);
  import vmn_pkg::*;

  state_t                 state_r, state_nxt;
  logic [MODE_BITS-1:0]   norm_mode_r, norm_mode_nxt;
  logic [EXT_BITS-1:0]    extent_r, extent_nxt;
  logic [MAG_BITS-1:0]    a_r, a_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic [SQ_BITS-1:0]     sq_sum_r, sq_sum_nxt;
  logic [ACC_BITS-1:0]    abs_sum_r, abs_sum_nxt;
  logic [ACC_BITS-1:0]    peak_r, peak_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [MAX_DIM-1:0]     col_vld_r, col_vld_nxt;
  logic [ACC_BITS-1:0]    rd_data_r;
  logic [NORM_BITS-1:0]   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NORM_BITS-1:0]   out_norm_value_r, out_norm_value_nxt;

  logic [ACC_BITS-1:0]    col_mem [MAX_DIM];
  logic                   mem_we;

  mode_t                  mode;
  logic                   matrix;
  logic [EXT_BITS-1:0]    side_v;
  logic [SIDE_BITS-1:0]   side_m;
  logic [CNT_BITS-1:0]    total;
  logic [ACC_BITS-1:0]    col_new;
  logic [ACC_BITS-1:0]    abs_new;
  logic                   col_last;
  logic [SQ_BITS-1:0]     sq_new;
  logic                   clear;
  logic                   root_start;
  logic                   root_done;
  logic [ROOT_BITS-1:0]   root;

  assign mode   = (norm_mode_r > MODE_BITS'(MODE_FROB)) ? MODE_VEC_L1 : mode_t'(norm_mode_r);
  assign matrix = (mode == MODE_MAT_INF) || (mode == MODE_MAT_L1) || (mode == MODE_FROB);

  always_comb begin
    if (extent_r == '0) begin
      side_v = EXT_BITS'(1);
      side_m = SIDE_BITS'(1);
    end else begin
      side_v = (extent_r > EXT_BITS'(MAX_LEN)) ? EXT_BITS'(MAX_LEN) : extent_r;
      side_m = (extent_r > EXT_BITS'(MAX_DIM)) ? SIDE_BITS'(MAX_DIM) : extent_r[SIDE_BITS-1:0];
    end
  end

  assign total    = matrix ? CNT_BITS'(side_m) * CNT_BITS'(side_m) : CNT_BITS'(side_v);
  assign col_new  = (col_vld_r[col_r] ? rd_data_r : '0) + ACC_BITS'(a_r);
  assign abs_new  = abs_sum_r + ACC_BITS'(a_r);
  assign col_last = ({1'b0, col_r} == (side_m - SIDE_BITS'(1)));
  assign sq_new   = sq_sum_r + SQ_BITS'(prod_r);
  assign in_ready = (state_r == ST_IDLE);

  vmn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sq_new),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    state_nxt          = state_r;
    norm_mode_nxt      = norm_mode_r;
    extent_nxt         = extent_r;
    a_nxt              = a_r;
    prod_nxt           = prod_r;
    sq_sum_nxt         = sq_sum_r;
    abs_sum_nxt        = abs_sum_r;
    peak_nxt           = peak_r;
    count_nxt          = count_r;
    col_nxt            = col_r;
    col_vld_nxt        = col_vld_r;
    res_nxt            = res_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_norm_value_nxt = out_norm_value_r;
    mem_we             = 1'b0;
    root_start         = 1'b0;
    clear              = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt     = magnitude(in_element);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt    = PROD_BITS'(a_r) * PROD_BITS'(a_r);
        abs_sum_nxt = abs_new;
        if (mode == MODE_VEC_MAX && ACC_BITS'(a_r) > peak_r) begin
          peak_nxt = ACC_BITS'(a_r);
        end
        if (mode == MODE_MAT_INF && col_last) begin
          if (abs_new > peak_r) begin
            peak_nxt = abs_new;
          end
          abs_sum_nxt = '0;
        end
        if (mode == MODE_MAT_L1) begin
          mem_we             = 1'b1;
          col_vld_nxt[col_r] = 1'b1;
          if (col_new > peak_r) begin
            peak_nxt = col_new;
          end
        end
        if (matrix) begin
          col_nxt = col_last ? '0 : col_r + COL_BITS'(1);
        end
        count_nxt = count_r + CNT_BITS'(1);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        sq_sum_nxt = sq_new;
        if (count_r == total) begin
          if (mode == MODE_VEC_L2 || mode == MODE_FROB) begin
            root_start = 1'b1;
            state_nxt  = ST_ROOT;
          end else begin
            if (mode == MODE_VEC_L1) begin
              res_nxt = NORM_BITS'(abs_sum_r);
            end else begin
              res_nxt = NORM_BITS'(peak_r);
            end
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          res_nxt   = NORM_BITS'(root);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_norm_value_nxt = res_r;
          clear              = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NORM_MODE: norm_mode_nxt = cfg_data[MODE_BITS-1:0];
        REG_EXTENT:    extent_nxt    = cfg_data[EXT_BITS-1:0];
        default:       extent_nxt    = extent_r;
      endcase
      clear = 1'b1;
    end

    if (clear) begin
      sq_sum_nxt  = '0;
      abs_sum_nxt = '0;
      peak_nxt    = '0;
      count_nxt   = '0;
      col_nxt     = '0;
      col_vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      norm_mode_r <= MODE_BITS'(MODE_VEC_L1);
      extent_r    <= EXTENT_RESET;
      sq_sum_r    <= '0;
      abs_sum_r   <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      col_r       <= '0;
      col_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      norm_mode_r <= norm_mode_nxt;
      extent_r    <= extent_nxt;
      sq_sum_r    <= sq_sum_nxt;
      abs_sum_r   <= abs_sum_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      col_r       <= col_nxt;
      col_vld_r   <= col_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r              <= a_nxt;
    prod_r           <= prod_nxt;
    res_r            <= res_nxt;
    out_norm_value_r <= out_norm_value_nxt;
  end

  // column sums: read every cycle, read-modify-write in ST_MUL
  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[col_r] <= col_new;
    end
    rd_data_r <= col_mem[col_r];
  end

  assign out_valid      = out_valid_r;
  assign out_norm_value = out_norm_value_r;

endmodule

`default_nettype wire

// ===== sv/vmn_checker.sv =====
// vmn_checker: port-level assertions for vector_matrix_norm_unit_top, with bind.
// Depends on vmn_pkg for widths.
`default_nettype none

module vmn_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               cfg_we,
  input wire logic [vmn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input wire logic [vmn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic signed [vmn_pkg::ELEM_BITS-1:0] in_element,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [vmn_pkg::NORM_BITS-1:0]      out_norm_value
);
  import vmn_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_norm_value))
    else $error("result changed while stalled");

  // one element in flight: busy right after a transfer
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after input transfer");

  // a result never appears the cycle after an element transfer
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too soon after input transfer");

  // norms never exceed 2^35
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_value <= (NORM_BITS'(1) << (NORM_BITS - 1)))
    else $error("norm out of range");

endmodule

bind vector_matrix_norm_unit_top vmn_checker u_vmn_checker (.*);

`default_nettype wire
